/* hdl/dpt_pkg.sv */
// Package: item types, opcodes and status codes for the distance priority table.
package dpt_pkg;

    localparam int TableDepth = 64;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);

    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_REMOVE   = 2'd1;
    localparam logic [1:0] KIND_RECENTER = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        entry_id;
        logic signed [15:0] entry_x;
        logic signed [15:0] entry_y;
        logic signed [15:0] new_center_x;
        logic signed [15:0] new_center_y;
        logic [5:0]         slot_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         count;
        logic [15:0]        out_id;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [16:0]        out_distance;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        distance;
    } t_entry;

    function automatic logic [16:0] manhattan(input logic signed [15:0] x,
                                              input logic signed [15:0] y,
                                              input logic signed [15:0] cx,
                                              input logic signed [15:0] cy);
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [16:0]        ax;
        logic [16:0]        ay;
        dx = 17'(x) - 17'(cx);
        dy = 17'(y) - 17'(cy);
        ax = dx[16] ? 17'(-dx) : 17'(dx);
        ay = dy[16] ? 17'(-dy) : 17'(dy);
        return ax + ay;
    endfunction

endpackage

/* hdl/dpt_front.sv */
// Front end: accepts items into a two-entry queue toward the table engine.
module dpt_front import dpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_in_item o_q_item
);
    t_in_item   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue overfilled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_q_valid) else $error("valid on empty queue");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("ready while full");
endmodule

/* hdl/dpt_engine.sv */
// Back end: table memory, sequencer for add, remove, resort and read, output register.
module dpt_engine import dpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    input  t_in_item  i_q_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDWT  = 4'd1;
    localparam logic [3:0] S_RDO   = 4'd2;
    localparam logic [3:0] S_SRCH  = 4'd3;
    localparam logic [3:0] S_SHIFT = 4'd4;
    localparam logic [3:0] S_DIST  = 4'd5;
    localparam logic [3:0] S_REV   = 4'd6;
    localparam logic [3:0] S_REVW  = 4'd7;
    localparam logic [3:0] S_INS   = 4'd8;
    localparam logic [3:0] S_INSC  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_SRCHW = 4'd11;
    localparam logic [3:0] S_INSP  = 4'd12;

    t_entry r_mem [TableDepth];
    t_entry r_rd;
    logic [AddrW-1:0] r_raddr, w_raddr;
    logic             w_we;
    logic [AddrW-1:0] w_waddr;
    t_entry           w_wdata;

    logic [3:0]       r_st, n_st;
    logic [CntW-1:0]  r_held, n_held;
    logic signed [15:0] r_cx, r_cy, n_cx, n_cy;
    t_in_item         r_it, n_it;
    logic [CntW-1:0]  r_i, n_i, r_j, n_j;
    t_entry           r_tmp, n_tmp, r_key, n_key;
    logic             r_ph, n_ph;
    t_out_item        r_out, n_out;
    logic             r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        n_st = r_st; n_held = r_held; n_cx = r_cx; n_cy = r_cy; n_it = r_it;
        n_i = r_i; n_j = r_j; n_tmp = r_tmp; n_key = r_key; n_ph = r_ph;
        n_out = r_out; n_ov = r_ov;
        w_raddr = r_raddr; w_we = 1'b0; w_waddr = '0; w_wdata = r_rd;
        o_q_pop = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_q_valid && (!r_ov || i_ready)) begin
                    o_q_pop = 1'b1;
                    n_it = i_q_item;
                    n_out = '0;
                    n_i = '0;
                    case (i_q_item.kind)
                        KIND_ADD: begin
                            if (r_held == CntW'(TableDepth)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_we = 1'b1;
                                w_waddr = r_held[AddrW-1:0];
                                w_wdata = '{i_q_item.entry_id, i_q_item.entry_x,
                                    i_q_item.entry_y, manhattan(i_q_item.entry_x,
                                    i_q_item.entry_y, r_cx, r_cy)};
                                n_held = r_held + 1'b1;
                            end
                            n_st = S_DONE;
                        end
                        KIND_REMOVE: begin
                            n_out.status = ST_NOT_FOUND;
                            w_raddr = '0;
                            n_st = (r_held == '0) ? S_DONE : S_SRCHW;
                        end
                        KIND_RECENTER: begin
                            if (i_q_item.new_center_x != r_cx
                                || i_q_item.new_center_y != r_cy) begin
                                n_cx = i_q_item.new_center_x;
                                n_cy = i_q_item.new_center_y;
                                w_raddr = '0;
                                n_st = (r_held == '0) ? S_DONE : S_DIST;
                                n_ph = 1'b0;
                            end else begin
                                n_st = S_DONE;
                            end
                        end
                        default: begin
                            if (CntW'(i_q_item.slot_index) < r_held) begin
                                w_raddr = i_q_item.slot_index[AddrW-1:0];
                                n_st = S_RDWT;
                            end else begin
                                n_out.status = ST_EMPTY;
                                n_st = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_RDWT: n_st = S_RDO;
            S_RDO: begin
                n_out.out_id = r_rd.id; n_out.out_x = r_rd.x;
                n_out.out_y = r_rd.y; n_out.out_distance = r_rd.distance;
                n_st = S_DONE;
            end
            S_SRCHW: n_st = S_SRCH;
            S_SRCH: begin
                if (r_rd.id == r_it.entry_id) begin
                    n_out.status = ST_OK;
                    n_j = r_i + 1'b1;
                    w_raddr = AddrW'(r_i + 1'b1);
                    n_ph = 1'b0;
                    n_st = (r_i + 1'b1 >= r_held) ? S_DONE : S_SHIFT;
                    n_held = r_held - 1'b1;
                end else if (r_i + 1'b1 >= r_held) begin
                    n_st = S_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                    w_raddr = AddrW'(r_i + 1'b1);
                    n_st = S_SRCHW;
                end
            end
            S_SHIFT: begin
                // r_j: source index; phase 0 waits on read, phase 1 writes j-1
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    w_we = 1'b1;
                    w_waddr = AddrW'(r_j - 1'b1);
                    w_wdata = r_rd;
                    n_ph = 1'b0;
                    if (r_j + 1'b1 > r_held) begin
                        n_st = S_DONE;
                    end else begin
                        n_j = r_j + 1'b1;
                        w_raddr = AddrW'(r_j + 1'b1);
                    end
                end
            end
            S_DIST: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    w_we = 1'b1;
                    w_waddr = AddrW'(r_i);
                    w_wdata = r_rd;
                    w_wdata.distance = manhattan(r_rd.x, r_rd.y, r_cx, r_cy);
                    n_ph = 1'b0;
                    if (r_i + 1'b1 >= r_held) begin
                        n_i = '0;
                        n_j = r_held - 1'b1;
                        w_raddr = '0;
                        n_st = (r_held < CntW'(2)) ? S_DONE : S_REV;
                    end else begin
                        n_i = r_i + 1'b1;
                        w_raddr = AddrW'(r_i + 1'b1);
                    end
                end
            end
            S_REV: begin
                // swap r_i and r_j: read i, read j, write i, write j
                if (!r_ph) begin
                    n_tmp = r_rd;
                    n_ph = 1'b1;
                    w_raddr = AddrW'(r_j);
                end else begin
                    n_st = S_REVW;
                    n_ph = 1'b0;
                end
            end
            S_REVW: begin
                if (!r_ph) begin
                    n_key = r_rd;
                    w_we = 1'b1; w_waddr = AddrW'(r_i); w_wdata = r_rd;
                    n_ph = 1'b1;
                end else begin
                    w_we = 1'b1; w_waddr = AddrW'(r_j); w_wdata = r_tmp;
                    n_ph = 1'b0;
                    if (r_i + 1'b1 >= r_j - 1'b1) begin
                        n_i = CntW'(1);
                        w_raddr = AddrW'(1);
                        n_st = S_INS;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = r_j - 1'b1;
                        w_raddr = AddrW'(r_i + 1'b1);
                        n_st = S_REV;
                    end
                end
            end
            S_INS: begin
                // load key = mem[i]; then j = i
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_key = r_rd;
                    n_j = r_i;
                    w_raddr = AddrW'(r_i - 1'b1);
                    n_ph = 1'b0;
                    n_st = S_INSC;
                end
            end
            S_INSC: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_rd.distance < r_key.distance) begin
                        w_we = 1'b1; w_waddr = AddrW'(r_j); w_wdata = r_rd;
                        n_j = r_j - 1'b1;
                        if (r_j == CntW'(1)) begin
                            n_st = S_INSP;
                        end else begin
                            w_raddr = AddrW'(r_j - 2'd2);
                        end
                    end else begin
                        w_we = 1'b1; w_waddr = AddrW'(r_j); w_wdata = r_key;
                        if (r_i + 1'b1 >= r_held) begin
                            n_st = S_DONE;
                        end else begin
                            n_i = r_i + 1'b1;
                            w_raddr = AddrW'(r_i + 1'b1);
                            n_st = S_INS;
                        end
                    end
                end
            end
            S_INSP: begin
                // key goes to the first slot
                w_we = 1'b1; w_waddr = AddrW'(r_j); w_wdata = r_key;
                n_ph = 1'b0;
                if (r_i + 1'b1 >= r_held) begin
                    n_st = S_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                    w_raddr = AddrW'(r_i + 1'b1);
                    n_st = S_INS;
                end
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_out.count = 7'(r_held);
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_it <= n_it; r_i <= n_i; r_j <= n_j; r_tmp <= n_tmp; r_key <= n_key;
        r_out <= n_out; r_raddr <= w_raddr;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_held <= '0; r_cx <= '0; r_cy <= '0;
            r_ph <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_held <= n_held; r_cx <= n_cx; r_cy <= n_cy;
            r_ph <= n_ph; r_ov <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CntW'(TableDepth)) else $error("count above depth");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_st == S_IDLE) else $error("pop outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_out)) else $error("result lost");
endmodule

/* hdl/distance_priority_table_top.sv */
// Top level: distance priority table, queue front end and table engine.
// One result per item. An add writes the new entry at the end of the table, a
// read fetches one slot, and a remove searches slot by slot and then shifts the later
// entries down. A recenter rewrites every distance, reverses the table and
// insertion-sorts it through the table memory, which has one read and one write port.
// A two-item queue lets the source run ahead while the engine works.
module distance_priority_table_top import dpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    logic     w_qv, w_pop;
    t_in_item w_qi;

    dpt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_item(w_qi)
    );

    dpt_engine u_engine (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_item(w_qi),
        .o_valid, .i_ready, .o_item
    );
endmodule

/* dv/distance_priority_table_top_tb.sv */
// Testbench: distance priority table top, self-checking against an in-bench table model.
module distance_priority_table_top_tb;
    import dpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 20000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    distance_priority_table_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    // table model
    t_entry             tbl [TableDepth];
    int                 held;
    logic signed [15:0] cen_x;
    logic signed [15:0] cen_y;

    t_out_item expected_results [$];
    int        mismatches;
    int        cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off;
    logic [15:0] used_ids [$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[distance_priority_table_top] ERROR");
            $finish;
        end
    end

    function automatic logic [16:0] dist_of(logic signed [15:0] x, logic signed [15:0] y);
        int dx;
        int dy;
        dx = int'(x) - int'(cen_x);
        dy = int'(y) - int'(cen_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return 17'(dx + dy);
    endfunction

    function automatic t_out_item table_apply(t_in_item it);
        t_out_item r;
        t_entry    t;
        int        j;
        r = '0;
        r.status = ST_OK;
        case (it.kind)
            KIND_ADD: begin
                if (held >= TableDepth) begin
                    r.status = ST_FULL;
                end else begin
                    tbl[held] = '{it.entry_id, it.entry_x, it.entry_y,
                                  dist_of(it.entry_x, it.entry_y)};
                    held++;
                end
            end
            KIND_REMOVE: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < held; i++) begin
                    if (tbl[i].id == it.entry_id) begin
                        for (int k = i; k + 1 < held; k++) tbl[k] = tbl[k + 1];
                        held--;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            KIND_RECENTER: begin
                if (it.new_center_x != cen_x || it.new_center_y != cen_y) begin
                    cen_x = it.new_center_x;
                    cen_y = it.new_center_y;
                    for (int i = 0; i < held; i++)
                        tbl[i].distance = dist_of(tbl[i].x, tbl[i].y);
                    for (int i = 0; i < held / 2; i++) begin
                        t = tbl[i];
                        tbl[i] = tbl[held - 1 - i];
                        tbl[held - 1 - i] = t;
                    end
                    for (int i = 1; i < held; i++) begin
                        j = i;
                        while (j > 0 && tbl[j - 1].distance < tbl[j].distance) begin
                            t = tbl[j - 1];
                            tbl[j - 1] = tbl[j];
                            tbl[j] = t;
                            j--;
                        end
                    end
                end
            end
            default: begin
                if (int'(it.slot_index) < held) begin
                    r.out_id       = tbl[it.slot_index].id;
                    r.out_x        = tbl[it.slot_index].x;
                    r.out_y        = tbl[it.slot_index].y;
                    r.out_distance = tbl[it.slot_index].distance;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
        endcase
        r.count = 7'(held);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (out_item.status != want.status)
                    report_mismatch("status", out_item.status, want.status);
                if (out_item.count != want.count)
                    report_mismatch("count", out_item.count, want.count);
                if (out_item.out_id != want.out_id)
                    report_mismatch("out_id", out_item.out_id, want.out_id);
                if (out_item.out_x != want.out_x)
                    report_mismatch("out_x", out_item.out_x, want.out_x);
                if (out_item.out_y != want.out_y)
                    report_mismatch("out_y", out_item.out_y, want.out_y);
                if (out_item.out_distance != want.out_distance)
                    report_mismatch("out_distance", out_item.out_distance,
                                    want.out_distance);
            end
        end
    end

    always @(posedge clk) begin
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(table_apply(it));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    function automatic t_in_item mk(logic [1:0] k, logic [15:0] id, logic [15:0] x,
                                    logic [15:0] y, logic [15:0] cx, logic [15:0] cy,
                                    logic [5:0] s);
        t_in_item it;
        it = '{k, id, x, y, cx, cy, s};
        return it;
    endfunction

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rnd_item();
        t_in_item it;
        int       r;
        it = '0;
        it.slot_index = 6'($urandom);
        it.entry_x = rnd_coord();
        it.entry_y = rnd_coord();
        it.new_center_x = rnd_coord();
        it.new_center_y = rnd_coord();
        it.entry_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
        if (it.entry_id <= 20) it.entry_id = it.entry_id * 16'hcccd;
        r = $urandom_range(99);
        if (r < 40) begin
            it.kind = KIND_ADD;
            used_ids.push_back(it.entry_id);
        end else if (r < 60) begin
            it.kind = KIND_REMOVE;
            if (used_ids.size() != 0 && $urandom_range(3) != 0)
                it.entry_id = used_ids[$urandom_range(used_ids.size() - 1)];
        end else if (r < 68) begin
            it.kind = KIND_RECENTER;
            if ($urandom_range(4) == 0) begin
                it.new_center_x = cen_x;
                it.new_center_y = cen_y;
            end
        end else begin
            it.kind = KIND_READ;
        end
        return it;
    endfunction

    task automatic test_directed();
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 0));
        send_item(mk(KIND_REMOVE, 16'hffff, 0, 0, 0, 0, 0));
        send_item(mk(KIND_RECENTER, 0, 0, 0, 0, 0, 0));
        send_item(mk(KIND_ADD, 16'hffff, 16'h7fff, 16'h8000, 0, 0, 0));
        send_item(mk(KIND_ADD, 0, 16'h8000, 16'h7fff, 0, 0, 0));
        send_item(mk(KIND_ADD, 16'h1234, 16'h0005, 16'hfffb, 0, 0, 0));
        send_item(mk(KIND_ADD, 16'h1234, 16'hfffb, 16'h0005, 0, 0, 0));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 0));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 6'd3));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 6'd63));
        send_item(mk(KIND_RECENTER, 0, 0, 0, 16'h8000, 16'h7fff, 0));
        send_item(mk(KIND_RECENTER, 0, 0, 0, 16'h8000, 16'h7fff, 0));
        for (int i = 0; i < 4; i++) send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 6'(i)));
        send_item(mk(KIND_REMOVE, 16'h1234, 0, 0, 0, 0, 0));
        send_item(mk(KIND_RECENTER, 0, 0, 0, 16'h7fff, 16'h8000, 0));
        for (int i = 0; i < 3; i++) send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 6'(i)));
    endtask

    task automatic test_fill_and_full();
        while (held < TableDepth)
            send_item(mk(KIND_ADD, 16'($urandom_range(7)), rnd_coord(), rnd_coord(), 0, 0, 0));
        send_item(mk(KIND_ADD, 16'h5555, 16'h7fff, 16'h7fff, 0, 0, 0));
        send_item(mk(KIND_RECENTER, 0, 0, 0, 16'($urandom), 16'($urandom), 0));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0, 6'd63));
        send_item(mk(KIND_REMOVE, 16'd3, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_item(rnd_item());
    endtask

    task automatic test_backpressure();
        hold_off <= 300;
        for (int i = 0; i < 20; i++) send_item(rnd_item());
        drain();
        repeat (50) @(posedge clk);
        test_random(20);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        hold_off = 0;
        held = 0;
        cen_x = '0;
        cen_y = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_full();
        send_idle_pct = 8;
        recv_idle_pct = 73;
        test_random(450);
        send_idle_pct = 73;
        recv_idle_pct = 8;
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(500);
        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[distance_priority_table_top] OK");
        end else begin
            $display("[distance_priority_table_top] ERROR");
        end
        $finish;
    end
endmodule
